[src/rsa3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa3_pkg: shared types and constants
// Widths, register indexes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package rsa3_pkg;

	localparam int EXP_WIDTH  = 32;
	localparam int MOD_WIDTH  = 31;
	localparam int PROD_WIDTH = 2 * MOD_WIDTH;
	localparam int CFG_WIDTH  = 32;
	localparam int EXP_CNT_W  = $clog2(EXP_WIDTH + 1);
	localparam int RED_CNT_W  = $clog2(PROD_WIDTH + 1);

	localparam logic [1:0] REG_EXPONENT = 2'd0;
	localparam logic [1:0] REG_MOD_A    = 2'd1;
	localparam logic [1:0] REG_MOD_B    = 2'd2;
	localparam logic [1:0] REG_MOD_C    = 2'd3;

	typedef struct packed {
		logic load;      // set acc to one; with wb_base, flag a zero reduced byte
		logic mul_acc;   // start acc * base
		logic mul_sq;    // start base * base
		logic red_step;  // one restoring reduction step
		logic red_init;  // load reduction of the plain byte
		logic wb_base;   // write reduced value to base
		logic wb_acc;    // write reduced value to acc
		logic shift_exp; // move to next exponent bit
	} rsa3_cmd_t;

	typedef struct packed {
		logic exp_bit;
		logic exp_done;
		logic red_done;
	} rsa3_sts_t;

endpackage

[src/rsa3_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa3_lane: one modulus lane of the datapath
// Holds base and accumulator and reduces a 62-bit product one bit a cycle.
// ----------------------------------------------------------------------------
module rsa3_lane import rsa3_pkg::*; (
	input  logic                 clk,
	input  rsa3_cmd_t            cmd,
	input  logic [7:0]           byte_in,
	input  logic [MOD_WIDTH-1:0] modulus,
	output logic [MOD_WIDTH-1:0] cipher
);

	logic [MOD_WIDTH-1:0]  base_q, acc_q, rem_q;
	logic [PROD_WIDTH-1:0] prod_q;
	logic                  zero_q;
	logic [MOD_WIDTH:0]    trial;

	// Restoring reduction: shift one product bit into the remainder.
	assign trial = {rem_q, prod_q[PROD_WIDTH-1]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= MOD_WIDTH'(1);
		end
		if (cmd.red_init) begin
			prod_q <= PROD_WIDTH'(byte_in);
			rem_q  <= '0;
		end else if (cmd.mul_acc) begin
			prod_q <= PROD_WIDTH'(acc_q) * PROD_WIDTH'(base_q);
			rem_q  <= '0;
		end else if (cmd.mul_sq) begin
			prod_q <= PROD_WIDTH'(base_q) * PROD_WIDTH'(base_q);
			rem_q  <= '0;
		end else if (cmd.red_step) begin
			prod_q <= {prod_q[PROD_WIDTH-2:0], 1'b0};
			if (trial >= {1'b0, modulus}) begin
				rem_q <= MOD_WIDTH'(trial - {1'b0, modulus});
			end else begin
				rem_q <= trial[MOD_WIDTH-1:0];
			end
		end
		if (cmd.wb_base) begin
			base_q <= rem_q;
		end
		if (cmd.wb_acc) begin
			acc_q <= rem_q;
		end
	end

	// A byte that reduces to zero, or a zero modulus, gives a zero cipher.
	assign cipher = (modulus == '0 || zero_q) ? '0 : acc_q;

	// The reduced byte is checked once, when it is first written to base.
	always_ff @(posedge clk) begin
		if (cmd.wb_base && cmd.load) begin
			zero_q <= (rem_q == '0);
		end
	end

endmodule

[src/rsa3_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa3_ctrl: sequencer for square-and-multiply
// Steps exponent bits and times each bit-serial reduction.
// ----------------------------------------------------------------------------
module rsa3_ctrl import rsa3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  rsa3_sts_t sts,
	output rsa3_cmd_t cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_RINIT = 7'b0000010,
		ST_BIT   = 7'b0000100,
		ST_RACC  = 7'b0001000,
		ST_SQ    = 7'b0010000,
		ST_RSQ   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (start) state_q <= ST_RINIT;
				ST_RINIT: if (sts.red_done) state_q <= ST_BIT;
				ST_BIT: begin
					if (sts.exp_done) state_q <= ST_DONE;
					else if (sts.exp_bit) state_q <= ST_RACC;
					else state_q <= ST_RSQ;
				end
				ST_RACC:  if (sts.red_done) state_q <= ST_SQ;
				ST_SQ:    state_q <= ST_RSQ;
				ST_RSQ:   if (sts.red_done) state_q <= ST_BIT;
				ST_DONE:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load     = start;
				cmd.red_init = start;
			end
			ST_RINIT: begin
				cmd.red_step = !sts.red_done;
				cmd.wb_base  = sts.red_done;
				cmd.load     = sts.red_done;
			end
			ST_BIT: begin
				cmd.mul_acc = !sts.exp_done && sts.exp_bit;
				cmd.mul_sq  = !sts.exp_done && !sts.exp_bit;
			end
			ST_RACC: begin
				cmd.red_step = !sts.red_done;
				cmd.wb_acc   = sts.red_done;
			end
			ST_SQ:   cmd.mul_sq = 1'b1;
			ST_RSQ: begin
				cmd.red_step  = !sts.red_done;
				cmd.wb_base   = sts.red_done;
				cmd.shift_exp = sts.red_done;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

[src/rsa3_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa3_dpath: datapath with three modulus lanes
// Holds the exponent shifter and reduction step counter shared by the lanes.
// ----------------------------------------------------------------------------
module rsa3_dpath import rsa3_pkg::*; (
	input  logic                 clk,
	input  rsa3_cmd_t            cmd,
	input  logic [7:0]           message_byte,
	input  logic [EXP_WIDTH-1:0] exponent,
	input  logic [MOD_WIDTH-1:0] mod_a,
	input  logic [MOD_WIDTH-1:0] mod_b,
	input  logic [MOD_WIDTH-1:0] mod_c,
	output rsa3_sts_t            sts,
	output logic [MOD_WIDTH-1:0] cipher_a,
	output logic [MOD_WIDTH-1:0] cipher_b,
	output logic [MOD_WIDTH-1:0] cipher_c
);

	logic [EXP_WIDTH-1:0] exp_q;
	logic [EXP_CNT_W-1:0] bits_q;
	logic [RED_CNT_W-1:0] red_q;

	always_ff @(posedge clk) begin
		if (cmd.red_init) begin
			exp_q  <= exponent;
			bits_q <= '0;
		end else if (cmd.shift_exp) begin
			exp_q  <= exp_q >> 1;
			bits_q <= bits_q + 1'b1;
		end
		if (cmd.red_init || cmd.mul_acc || cmd.mul_sq) begin
			red_q <= '0;
		end else if (cmd.red_step) begin
			red_q <= red_q + 1'b1;
		end
	end

	assign sts.exp_bit  = exp_q[0];
	assign sts.exp_done = (bits_q == EXP_CNT_W'(EXP_WIDTH));
	assign sts.red_done = (red_q == RED_CNT_W'(PROD_WIDTH));

	rsa3_lane u_lane_a (.clk, .cmd, .byte_in(message_byte), .modulus(mod_a), .cipher(cipher_a));
	rsa3_lane u_lane_b (.clk, .cmd, .byte_in(message_byte), .modulus(mod_b), .cipher(cipher_b));
	rsa3_lane u_lane_c (.clk, .cmd, .byte_in(message_byte), .modulus(mod_c), .cipher(cipher_c));

endmodule

[src/rsa_encrypt_three_moduli.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_encrypt_three_moduli: modular exponentiation of a byte, three moduli
// Right-to-left square-and-multiply with bit-serial 62-bit reduction.
// ----------------------------------------------------------------------------
//  channel   ports                                  handshake
//  input     message_byte                           start & !busy
//  result    cipher_a, cipher_b, cipher_c           done, one cycle
//  config    cfg_we, cfg_index, cfg_data            cfg_we
//
// Each beat holds busy through the initial reduction of the byte, then one squaring
// reduction for each of the 32 exponent bits, preceded by a multiply reduction for a set bit;
// every reduction steps through all 62 product bits. Reset clears the controller
// and loads the register reset values. The receiver cannot stall: done marks
// the result for one cycle, and the next beat is taken from the cycle after it.
// ----------------------------------------------------------------------------
module rsa_encrypt_three_moduli import rsa3_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [7:0]           message_byte,
	output logic                 done,
	output logic [MOD_WIDTH-1:0] cipher_a,
	output logic [MOD_WIDTH-1:0] cipher_b,
	output logic [MOD_WIDTH-1:0] cipher_c,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [CFG_WIDTH-1:0] cfg_data
);

	logic [EXP_WIDTH-1:0] exponent_q;
	logic [MOD_WIDTH-1:0] mod_a_q, mod_b_q, mod_c_q;
	rsa3_cmd_t            cmd;
	rsa3_sts_t            sts;

	// Configuration registers; the user must make writes only while idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= EXP_WIDTH'(3);
			mod_a_q    <= '1;
			mod_b_q    <= '1;
			mod_c_q    <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPONENT: exponent_q <= cfg_data[EXP_WIDTH-1:0];
				REG_MOD_A:    mod_a_q    <= cfg_data[MOD_WIDTH-1:0];
				REG_MOD_B:    mod_b_q    <= cfg_data[MOD_WIDTH-1:0];
				REG_MOD_C:    mod_c_q    <= cfg_data[MOD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	rsa3_ctrl u_ctrl (.clk, .arst_n, .start, .sts, .cmd, .busy, .done);

	rsa3_dpath u_dpath (
		.clk, .cmd, .message_byte, .exponent(exponent_q),
		.mod_a(mod_a_q), .mod_b(mod_b_q), .mod_c(mod_c_q),
		.sts, .cipher_a, .cipher_b, .cipher_c
	);

	// A result strobe is never back to back.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	// A result follows only a busy controller.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	// Start while idle always makes the block busy.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start lost");

endmodule
